@@ rtl/core/bps_pkg.sv @@
package bps_pkg;

	localparam int unsigned COUNT_W   = 18;
	localparam int unsigned ENERGY_W  = 33;
	localparam int unsigned THR_W     = 24;
	localparam int unsigned HANG_W    = 8;
	localparam int unsigned PWR_W     = 16;
	localparam int unsigned PROD_W    = THR_W + COUNT_W;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 24;
	localparam int unsigned COUNT_CAP = 262143;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = 2;

	localparam logic [1:0] EV_START   = 2'd0;
	localparam logic [1:0] EV_RECORD  = 2'd1;
	localparam logic [1:0] EV_END     = 2'd2;
	localparam logic [1:0] EV_DISPLAY = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HANG        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MIN = 2'd2;

	typedef struct packed {
		logic              action;
		logic signed [7:0] sample_i;
		logic signed [7:0] sample_q;
		logic              last_in_block;
	} in_word_t;

	typedef struct packed {
		logic [1:0]          event_res;
		logic [ENERGY_W-1:0] block_energy;
		logic [COUNT_W-1:0]  block_samples;
		logic                last_of_run;
	} out_word_t;

	typedef struct packed {
		logic [THR_W-1:0]   power_threshold_q8;
		logic [HANG_W-1:0]  hang_seconds;
		logic [COUNT_W-1:0] display_min_samples;
	} cfg_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic [COUNT_W-1:0]  samples;
		logic [3:0]          ev_mask;
	} blk_desc_t;

endpackage

@@ rtl/core/bps_front.sv @@
module bps_front import bps_pkg::*; #(
	parameter int unsigned MAX_BLOCK_SAMPLES = 131072
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  in_word_t  in_word,
	output logic      in_stall,
	input  cfg_t      cfg,
	output logic      push_valid,
	output blk_desc_t push_desc,
	input  logic      q_full
);

	localparam int unsigned BLOCK_LIMIT =
		(MAX_BLOCK_SAMPLES < COUNT_CAP) ? MAX_BLOCK_SAMPLES : COUNT_CAP;

	logic adv;

	logic               v_s1, tick_s1, last_s1;
	logic [PWR_W-1:0]   pw_s1;
	logic               v_s2, tick_s2;
	logic [ENERGY_W-1:0] en_s2;
	logic [COUNT_W-1:0] cnt_s2;
	logic               v_s3, tick_s3;
	logic [ENERGY_W-1:0] en_s3;
	logic [COUNT_W-1:0] cnt_s3;
	logic [PROD_W-1:0]  prod_s3;

	logic [ENERGY_W-1:0] acc_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic                rec_q;
	logic [HANG_W-1:0]   sec_q;

	logic signed [15:0]  sqi, sqq;
	logic [PWR_W-1:0]    pw;
	logic [ENERGY_W-1:0] new_en;
	logic [COUNT_W-1:0]  new_cnt;
	logic                blk_end;

	logic                loud;
	logic [HANG_W-1:0]   sec_inc, sec_blk, sec_nx;
	logic                rec_nx;
	logic [3:0]          mask;

	assign adv      = !q_full;
	assign in_stall = q_full;

	assign sqi = in_word.sample_i * in_word.sample_i;
	assign sqq = in_word.sample_q * in_word.sample_q;
	assign pw  = $unsigned(sqi) + $unsigned(sqq);

	assign new_en  = acc_q + {{(ENERGY_W-PWR_W){1'b0}}, pw_s1};
	assign new_cnt = cnt_q + 1'b1;
	assign blk_end = last_s1 || ({{(32-COUNT_W){1'b0}}, new_cnt} >= 32'(BLOCK_LIMIT));

	always_comb begin
		sec_inc = (sec_q == {HANG_W{1'b1}}) ? sec_q : sec_q + 1'b1;
		loud    = {1'b0, en_s3, 8'b0} > prod_s3;
		sec_blk = loud ? '0 : sec_q;
		mask    = '0;
		rec_nx  = rec_q;
		sec_nx  = sec_q;
		if (tick_s3) begin
			sec_nx = sec_inc;
		end else begin
			sec_nx = sec_blk;
			if (loud && !rec_q) begin
				mask[EV_START] = 1'b1;
				rec_nx         = 1'b1;
			end else begin
				if (rec_q) begin
					mask[EV_RECORD] = 1'b1;
					if (sec_blk >= cfg.hang_seconds) begin
						mask[EV_END] = 1'b1;
						rec_nx       = 1'b0;
					end
				end
				mask[EV_DISPLAY] = (cnt_s3 >= cfg.display_min_samples);
			end
		end
	end

	assign push_valid        = v_s3 && !tick_s3 && (|mask);
	assign push_desc.energy  = en_s3;
	assign push_desc.samples = cnt_s3;
	assign push_desc.ev_mask = mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			acc_q <= '0;
			cnt_q <= '0;
			rec_q <= 1'b0;
			sec_q <= '0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1 && (tick_s1 || blk_end);
			v_s3 <= v_s2;
			if (v_s1 && !tick_s1) begin
				if (blk_end) begin
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					acc_q <= new_en;
					cnt_q <= new_cnt;
				end
			end
			if (v_s3) begin
				rec_q <= rec_nx;
				sec_q <= sec_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tick_s1 <= in_word.action;
			last_s1 <= in_word.last_in_block;
			pw_s1   <= pw;
			tick_s2 <= tick_s1;
			en_s2   <= new_en;
			cnt_s2  <= new_cnt;
			tick_s3 <= tick_s2;
			en_s3   <= en_s2;
			cnt_s3  <= cnt_s2;
			prod_s3 <= cfg.power_threshold_q8 * cnt_s2;
		end
	end

endmodule

@@ rtl/core/bps_queue.sv @@
module bps_queue import bps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  blk_desc_t push_desc,
	output logic      full,
	output logic      head_valid,
	output blk_desc_t head_desc,
	input  logic      pop
);

	blk_desc_t       mem [QDEPTH];
	logic [QAW-1:0]  wr_q, rd_q;
	logic [QAW:0]    count_q;
	logic            do_push, do_pop;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_desc  = mem[rd_q];
	assign do_push    = push_valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_q] <= push_desc;
	end

endmodule

@@ rtl/core/bps_back.sv @@
module bps_back import bps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  blk_desc_t head_desc,
	output logic      pop,
	output logic      out_valid,
	output out_word_t out_word,
	input  logic      out_stall
);

	logic [3:0] done_q;
	logic [3:0] rem, pick;
	logic [1:0] code;
	logic       last, load;
	logic       out_v_q;
	out_word_t  out_q;

	assign rem = head_desc.ev_mask & ~done_q;

	always_comb begin
		pick = '0;
		code = EV_START;
		priority if (rem[EV_START]) begin
			pick[EV_START] = 1'b1;
			code           = EV_START;
		end else if (rem[EV_RECORD]) begin
			pick[EV_RECORD] = 1'b1;
			code            = EV_RECORD;
		end else if (rem[EV_END]) begin
			pick[EV_END] = 1'b1;
			code         = EV_END;
		end else begin
			pick[EV_DISPLAY] = 1'b1;
			code             = EV_DISPLAY;
		end
	end

	assign last      = ((rem & ~pick) == '0);
	assign load      = head_valid && (!out_v_q || !out_stall);
	assign pop       = load && last;
	assign out_valid = out_v_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			done_q  <= '0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				done_q  <= last ? '0 : (done_q | pick);
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.event_res     <= code;
			out_q.block_energy  <= head_desc.energy;
			out_q.block_samples <= head_desc.samples;
			out_q.last_of_run   <= last;
		end
	end

endmodule

@@ rtl/core/block_power_squelch_with_hang.sv @@
// Channel | Direction | Handshake                   | Word
// sample  | in        | sample_valid / sample_stall | in_word_t: tick or I/Q sample
// event   | out       | event_valid / event_stall   | out_word_t: recording or display event
// cfg     | in        | cfg_we, cfg_index, cfg_data | threshold, hang, display minimum
//
// One sample word is taken every cycle while the block queue has room.
// A block end yields up to three event words, sent one per cycle by the back end while event_stall is low.
// The first event word of a block passes the s1, s2 and s3 registers, the block queue and the back-end output register.
// sample_stall rises only when the four-entry block queue is full.
// Reset clears recording state, seconds counter, accumulators and queue; no clearing pass.
module block_power_squelch_with_hang import bps_pkg::*; #(
	parameter int unsigned MAX_BLOCK_SAMPLES = 131072
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  in_word_t             sample_word,
	output logic                 sample_stall,
	output logic                 event_valid,
	output out_word_t            event_word,
	input  logic                 event_stall,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	logic      push_valid, q_full, head_valid, pop;
	blk_desc_t push_desc, head_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_threshold_q8  <= 24'd26426;
			cfg_q.hang_seconds        <= 8'd8;
			cfg_q.display_min_samples <= 18'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD:   cfg_q.power_threshold_q8  <= cfg_data[THR_W-1:0];
				REG_HANG:        cfg_q.hang_seconds        <= cfg_data[HANG_W-1:0];
				REG_DISPLAY_MIN: cfg_q.display_min_samples <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	bps_front #(
		.MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_valid),
		.in_word   (sample_word),
		.in_stall  (sample_stall),
		.cfg       (cfg_q),
		.push_valid(push_valid),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	bps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_desc (push_desc),
		.full      (q_full),
		.head_valid(head_valid),
		.head_desc (head_desc),
		.pop       (pop)
	);

	bps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_desc (head_desc),
		.pop       (pop),
		.out_valid (event_valid),
		.out_word  (event_word),
		.out_stall (event_stall)
	);

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	import bps_pkg::*;

	localparam int unsigned MAX_BLK     = 131072;
	localparam int unsigned BLOCK_LIMIT = (MAX_BLK < COUNT_CAP) ? MAX_BLK : COUNT_CAP;
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	in_word_t             sample_word = '0;
	logic                 sample_stall;
	logic                 event_valid;
	out_word_t            event_word;
	logic                 event_stall = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t ev;
	} row_t;

	out_word_t pending_events [$];

	logic        rec_on = 1'b0;
	logic [7:0]  secs = 8'd0;
	logic [32:0] acc = '0;
	logic [17:0] cnt = '0;

	logic [23:0] thr_q8 = 24'd26426;
	logic [7:0]  hang_s = 8'd8;
	logic [17:0] disp_min = 18'd1024;

	bit sender_idles = 1'b1;
	bit recv_idles = 1'b1;
	int errors = 0;
	int n_samples = 0;
	int n_ticks = 0;
	int n_events = 0;
	int n_settings = 0;

	row_t dir_rows [20] = '{
		'{'{ACT_SAMPLE, 8'sd127, 8'sd127, 1'b1}, 1'b1, '{EV_START, 33'd32258, 18'd1, 1'b1}},
		'{'{ACT_SAMPLE, 8'sd0, 8'sd0, 1'b1}, 1'b1, '{EV_RECORD, 33'd0, 18'd1, 1'b1}},
		'{'{ACT_TICK, 8'sh80, 8'sd127, 1'b1}, 1'b0, '0},
		'{'{ACT_TICK, 8'sd0, 8'sd0, 1'b0}, 1'b0, '0},
		'{'{ACT_SAMPLE, 8'sh80, 8'sh80, 1'b0}, 1'b0, '0},
		'{'{ACT_SAMPLE, 8'sh80, 8'sd127, 1'b0}, 1'b0, '0},
		'{'{ACT_SAMPLE, 8'sd127, 8'sh80, 1'b1}, 1'b0, '0},
		'{'{ACT_SAMPLE, 8'sd1, 8'shff, 1'b1}, 1'b0, '0},
		'{'{ACT_SAMPLE, 8'shff, 8'sd0, 1'b0}, 1'b0, '0},
		'{'{ACT_SAMPLE, 8'sd0, 8'sh80, 1'b1}, 1'b0, '0},
		'{'{ACT_TICK, 8'sd5, 8'sh81, 1'b0}, 1'b0, '0},
		'{'{ACT_TICK, 8'sh7e, 8'sd3, 1'b1}, 1'b0, '0},
		'{'{ACT_TICK, 8'sd0, 8'sd0, 1'b0}, 1'b0, '0},
		'{'{ACT_TICK, 8'shff, 8'shff, 1'b1}, 1'b0, '0},
		'{'{ACT_TICK, 8'sd0, 8'sd0, 1'b0}, 1'b0, '0},
		'{'{ACT_TICK, 8'sd0, 8'sd0, 1'b0}, 1'b0, '0},
		'{'{ACT_TICK, 8'sd0, 8'sd0, 1'b0}, 1'b0, '0},
		'{'{ACT_TICK, 8'sd0, 8'sd0, 1'b0}, 1'b0, '0},
		'{'{ACT_SAMPLE, 8'sd2, 8'sd2, 1'b1}, 1'b0, '0},
		'{'{ACT_SAMPLE, 8'sd127, 8'sd127, 1'b1}, 1'b1, '{EV_START, 33'd32258, 18'd1, 1'b1}}
	};

	block_power_squelch_with_hang #(
		.MAX_BLOCK_SAMPLES(MAX_BLK)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_word(sample_word),
		.sample_stall(sample_stall),
		.event_valid(event_valid),
		.event_word(event_word),
		.event_stall(event_stall),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic squelch_step(input in_word_t w, input bit keep);
		int          si;
		int          sq;
		int          n;
		logic [32:0] e;
		logic [17:0] c;
		logic [47:0] lhs;
		logic [47:0] rhs;
		out_word_t   evs [3];
		n = 0;
		if (w.action == ACT_TICK) begin
			if (secs != 8'd255)
				secs++;
			return;
		end
		si = w.sample_i;
		sq = w.sample_q;
		acc += 33'(si * si + sq * sq);
		cnt++;
		if (!w.last_in_block && cnt < BLOCK_LIMIT)
			return;
		e = acc;
		c = cnt;
		acc = '0;
		cnt = '0;
		lhs = {7'd0, e, 8'd0};
		rhs = 48'(thr_q8) * 48'(c);
		if (lhs > rhs) begin
			secs = 8'd0;
			if (!rec_on) begin
				rec_on = 1'b1;
				if (keep)
					pending_events.push_back('{EV_START, e, c, 1'b1});
				return;
			end
		end
		if (rec_on) begin
			evs[n] = '{EV_RECORD, e, c, 1'b0};
			n++;
			if (secs >= hang_s) begin
				evs[n] = '{EV_END, e, c, 1'b0};
				n++;
				rec_on = 1'b0;
			end
		end
		if (c >= disp_min) begin
			evs[n] = '{EV_DISPLAY, e, c, 1'b0};
			n++;
		end
		if (n > 0)
			evs[n-1].last_of_run = 1'b1;
		for (int k = 0; k < n; k++)
			if (keep)
				pending_events.push_back(evs[k]);
	endtask

	task automatic put_word(input in_word_t w, input bit keep);
		if (sender_idles && $urandom_range(0, 99) < 17) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_word <= w;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		if (w.action == ACT_TICK)
			n_ticks++;
		else
			n_samples++;
		squelch_step(w, keep);
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic cfg_set(input logic [23:0] thr, input logic [23:0] hang,
			input logic [23:0] disp);
		cfg_we <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= REG_HANG;
		cfg_data <= hang;
		@(posedge clk);
		cfg_index <= REG_DISPLAY_MIN;
		cfg_data <= disp;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_data <= 24'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_q8 = thr;
		hang_s = hang[7:0];
		disp_min = disp[17:0];
		n_settings++;
	endtask

	function automatic logic [7:0] pick_sample(input int mode);
		int v;
		case (mode)
			0: v = int'($urandom_range(0, 6)) - 3;
			1: v = int'($urandom_range(0, 255));
			default: begin
				v = int'($urandom_range(100, 128));
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v[7:0];
	endfunction

	task automatic run_random(input int n_items);
		int       sent;
		int       blen;
		int       mode;
		in_word_t w;
		sent = 0;
		while (sent < n_items) begin
			blen = $urandom_range(1, 6);
			mode = $urandom_range(0, 2);
			for (int k = 0; k < blen; k++) begin
				if ($urandom_range(0, 99) < 20) begin
					w = 18'($urandom);
					w.action = ACT_TICK;
					put_word(w, 1'b1);
					sent++;
				end
				w.action = ACT_SAMPLE;
				w.sample_i = pick_sample(mode);
				w.sample_q = pick_sample(mode);
				w.last_in_block = (k == blen - 1);
				put_word(w, 1'b1);
				sent++;
			end
		end
	endtask

	task automatic check_event(input out_word_t got);
		out_word_t want;
		n_events++;
		if (pending_events.size() == 0) begin
			errors++;
			$display("%0t: event word with nothing pending: ev=%0d energy=%0d samples=%0d last=%0d",
				$time, got.event_res, got.block_energy, got.block_samples, got.last_of_run);
			return;
		end
		want = pending_events.pop_front();
		if (got.event_res !== want.event_res || got.block_energy !== want.block_energy ||
				got.block_samples !== want.block_samples ||
				got.last_of_run !== want.last_of_run) begin
			errors++;
			$display("%0t: expected ev=%0d energy=%0d samples=%0d last=%0d", $time,
				want.event_res, want.block_energy, want.block_samples, want.last_of_run);
			$display("%0t: actual   ev=%0d energy=%0d samples=%0d last=%0d", $time,
				got.event_res, got.block_energy, got.block_samples, got.last_of_run);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && event_valid && !event_stall)
			check_event(event_word);
		event_stall <= recv_idles && ($urandom_range(0, 99) < 17);
	end

	initial begin
		#8000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		in_word_t w;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = 0; k < 20; k++) begin
			put_word(dir_rows[k].w, !dir_rows[k].typed);
			if (dir_rows[k].typed)
				pending_events.push_back(dir_rows[k].ev);
		end
		settle();

		cfg_set(24'd0, 24'd0, 24'd0);
		run_random(20);
		settle();

		// quiet stretch: no gaps on either side
		sender_idles = 1'b0;
		recv_idles <= 1'b0;
		cfg_set(24'd8000, 24'hAB02, 24'hFF0003);
		run_random(22);
		settle();
		sender_idles = 1'b1;
		recv_idles <= 1'b1;

		// hold the recording across a few ticks
		cfg_set(24'd100, 24'd255, 24'd2);
		w = '{ACT_SAMPLE, 8'sd127, 8'sd127, 1'b1};
		put_word(w, 1'b1);
		w.action = ACT_TICK;
		for (int k = 0; k < 5; k++)
			put_word(w, 1'b1);
		w = '{ACT_SAMPLE, 8'sd0, 8'sd0, 1'b1};
		put_word(w, 1'b1);
		run_random(12);
		settle();

		cfg_set(24'd8388608, 24'd255, 24'd131072);
		run_random(8);
		settle();

		// full-scale sample against the largest threshold just below it
		cfg_set(24'd8388607, 24'd1, 24'd131072);
		w = '{ACT_SAMPLE, 8'sh80, 8'sh80, 1'b1};
		put_word(w, 1'b1);
		w.action = ACT_TICK;
		put_word(w, 1'b1);
		put_word(w, 1'b1);
		w = '{ACT_SAMPLE, 8'sd0, 8'sd0, 1'b1};
		put_word(w, 1'b1);
		settle();

		cfg_set(24'd26426, 24'd8, 24'd1024);
		run_random(16);
		settle();

		$display("sent %0d sample words and %0d ticks over %0d register settings, %0d events checked",
			n_samples, n_ticks, n_settings, n_events);
		$display("run took in starts, hang expiry, zero settings and a full-scale block at the top threshold");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
